// File: design/rbre_pkg.sv
// Shared types and constants for the range bitmap run engine.
`default_nettype none
package rbre_pkg;
   localparam int DEPTH_DEFAULT = 4096;
   localparam int WORD_BITS = 8;
   localparam int POS_W = 12;
   localparam int ANS_W = 13;

   localparam logic [2:0] KIND_CLEAR = 3'd0;
   localparam logic [2:0] KIND_SET   = 3'd1;
   localparam logic [2:0] KIND_FLIP  = 3'd2;
   localparam logic [2:0] KIND_COUNT = 3'd3;
   localparam logic [2:0] KIND_RUN   = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PROC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [ANS_W-1:0] count;
      logic [ANS_W-1:0] run;
      logic [ANS_W-1:0] best;
   } stat_type;
endpackage
`default_nettype wire

// File: design/rbre_word_stat.sv
// Count and run statistics folded over one masked word of the bit store.
`default_nettype none
module rbre_word_stat (
   input  wire logic [rbre_pkg::WORD_BITS-1:0] data,
   input  wire logic [rbre_pkg::WORD_BITS-1:0] mask,
   input  wire rbre_pkg::stat_type             stat_in,
   output rbre_pkg::stat_type                  stat_out
);
   always_comb begin
      rbre_pkg::stat_type s;
      s = stat_in;
      for (int j = 0; j < rbre_pkg::WORD_BITS; j++) begin
         if (mask[j]) begin
            if (data[j]) begin
               s.count = s.count + 1'b1;
               s.run = s.run + 1'b1;
               if (s.run > s.best) begin
                  s.best = s.run;
               end
            end else begin
               s.run = '0;
            end
         end
      end
      stat_out = s;
   end
endmodule
`default_nettype wire

// File: design/range_bitmap_run_engine.sv
// Range bitmap run engine: word-serial read-modify-write (read only for count and run) over an 8-bit-wide bit store.
// Each 8-bit word touched by the range is read (ST_READ) and then processed (ST_PROC), then ST_FIN;
// an item that touches no word (reversed range, unused kind, start past the array) goes straight to ST_FIN.
// A new item is taken only in ST_IDLE, so not before the previous item has finished.
// A finished result waits in the output register while the next item is processed.
// Reset: a clearing pass writes zeros to all (DEPTH+7)/8 words, one per cycle, before any
// item is accepted.
`default_nettype none
module range_bitmap_run_engine #(
   parameter int DEPTH = rbre_pkg::DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_kind,
   input  wire logic [rbre_pkg::POS_W-1:0] req_range_start,
   input  wire logic [rbre_pkg::POS_W-1:0] req_range_end,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [rbre_pkg::ANS_W-1:0]      rsp_answer,
   output logic                            rsp_bad_range
);
   localparam int WB = rbre_pkg::WORD_BITS;
   localparam int PW = rbre_pkg::POS_W;
   localparam int NW = (DEPTH + WB - 1) / WB;
   localparam int AW = (NW > 1) ? $clog2(NW) : 1;
   localparam int WIW = PW - $clog2(WB);

   rbre_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [2:0]     kind_ff, kind_in;
   logic [PW-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [WIW-1:0] word_ff, word_in;
   logic           bad_ff, bad_in, query_ff, query_in, skip;
   rbre_pkg::stat_type stat_ff, stat_in, stat_next;
   logic           rsp_valid_ff, rsp_valid_in, load_rsp;
   logic [rbre_pkg::ANS_W-1:0] answer_ff, answer_in;
   logic           rsp_bad_ff, rsp_bad_in;

   logic [WB-1:0] mem [NW];
   logic [WB-1:0] rdata_ff, wdata, mask;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_addr;
   logic [AW+WIW-1:0] word_wide;
   logic [PW-1:0] hi_clamp;
   logic accept;

   assign accept = req_valid && !req_stall;
   assign word_wide = {{AW{1'b0}}, word_ff};

   always_comb begin
      hi_clamp = req_range_end;
      if (int'(req_range_end) >= DEPTH) begin
         hi_clamp = PW'(DEPTH - 1);
      end
      skip = (req_kind > rbre_pkg::KIND_RUN) || (req_range_start > req_range_end)
             || (int'(req_range_start) >= DEPTH);
   end

   always_comb begin
      logic [PW-1:0] p;
      for (int j = 0; j < WB; j++) begin
         p = {word_ff, 3'(j)};
         mask[j] = (p >= lo_ff) && (p <= hi_ff);
      end
   end

   rbre_word_stat u_stat (
      .data    (rdata_ff),
      .mask    (mask),
      .stat_in (stat_ff),
      .stat_out(stat_next)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbre_pkg::ST_CLEAR: if (clr_ff == AW'(NW - 1)) state_in = rbre_pkg::ST_IDLE;
         rbre_pkg::ST_IDLE:
            if (accept) state_in = skip ? rbre_pkg::ST_FIN : rbre_pkg::ST_READ;
         rbre_pkg::ST_READ:  state_in = rbre_pkg::ST_PROC;
         rbre_pkg::ST_PROC:
            state_in = (word_ff == hi_ff[PW-1:PW-WIW]) ? rbre_pkg::ST_FIN : rbre_pkg::ST_READ;
         rbre_pkg::ST_FIN:
            if (!query_ff || !rsp_valid_ff || !rsp_stall) state_in = rbre_pkg::ST_IDLE;
         default:  state_in = rbre_pkg::ST_CLEAR;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_stall = 1'b1;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_addr = word_wide[AW-1:0];
      wdata = '0;
      load_rsp = 1'b0;
      case (state_ff)
         rbre_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = clr_ff;
         end
         rbre_pkg::ST_IDLE: req_stall = 1'b0;
         rbre_pkg::ST_READ: mem_re = 1'b1;
         rbre_pkg::ST_PROC: begin
            case (kind_ff)
               rbre_pkg::KIND_CLEAR: begin mem_we = 1'b1; wdata = rdata_ff & ~mask; end
               rbre_pkg::KIND_SET:   begin mem_we = 1'b1; wdata = rdata_ff | mask; end
               rbre_pkg::KIND_FLIP:  begin mem_we = 1'b1; wdata = rdata_ff ^ mask; end
               default: mem_we = 1'b0;
            endcase
         end
         rbre_pkg::ST_FIN: load_rsp = query_ff && (!rsp_valid_ff || !rsp_stall);
         default: req_stall = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in = clr_ff;
      kind_in = kind_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      word_in = word_ff;
      bad_in = bad_ff;
      query_in = query_ff;
      stat_in = stat_ff;
      if (state_ff == rbre_pkg::ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end
      if (accept) begin
         kind_in = req_kind;
         lo_in = req_range_start;
         hi_in = hi_clamp;
         word_in = req_range_start[PW-1:PW-WIW];
         bad_in = req_range_start > req_range_end;
         query_in = (req_kind == rbre_pkg::KIND_COUNT) || (req_kind == rbre_pkg::KIND_RUN);
         stat_in = '0;
      end
      if (state_ff == rbre_pkg::ST_PROC) begin
         stat_in = stat_next;
         word_in = word_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      answer_in = answer_ff;
      rsp_bad_in = rsp_bad_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_bad_in = bad_ff;
         answer_in = bad_ff ? '0 :
                     (kind_ff == rbre_pkg::KIND_COUNT) ? stat_ff.count : stat_ff.best;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbre_pkg::ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      word_ff <= word_in;
      bad_ff <= bad_in;
      query_ff <= query_in;
      stat_ff <= stat_in;
      answer_ff <= answer_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_answer = answer_ff;
   assign rsp_bad_range = rsp_bad_ff;

   a_read_then_proc: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbre_pkg::ST_READ |=> state_ff == rbre_pkg::ST_PROC)
      else $error("read not followed by word update");
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == rbre_pkg::ST_CLEAR |-> req_stall)
      else $error("input taken during clearing pass");
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> state_ff == rbre_pkg::ST_FIN && query_ff)
      else $error("result loaded outside query finish");
endmodule
`default_nettype wire
